// ===== rtl/rswf_pkg.sv =====
`timescale 1ns / 1ps

package rswf_pkg;

  localparam int unsigned SlotCountDef = 64;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned SlotFieldW   = 16;
  localparam int unsigned KeyFieldW    = 32;
  localparam int unsigned CountW       = 32;
  localparam int unsigned ActiveW      = 7;

  typedef enum logic [1:0] {
    REQ_SET   = 2'd0,
    REQ_VOID  = 2'd1,
    REQ_INVAL = 2'd2,
    REQ_BUMP  = 2'd3
  } req_kind_e;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [SlotFieldW-1:0] slot;
    logic [KeyFieldW-1:0]  key;
  } req_t;

  typedef struct packed {
    logic              elide;
    logic              slot_overflow;
    logic [CountW-1:0] tex_gen;
    logic [CountW-1:0] elided_total;
    logic [CountW-1:0] applied_total;
    logic [CountW-1:0] voided_total;
    logic [CountW-1:0] invalidation_total;
    logic [CountW-1:0] overflow_total;
    logic [ActiveW-1:0] active_slots;
    logic              touched;
  } rsp_t;

endpackage

// ===== rtl/rswf_key_ram.sv =====
`timescale 1ns / 1ps

module rswf_key_ram #(
  parameter int unsigned DEPTH  = rswf_pkg::SlotCountDef,
  parameter int unsigned WIDTH  = rswf_pkg::KeyBitsDef,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read-before-write: a same-cycle write is forwarded by the caller.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/rswf_state.sv =====
`timescale 1ns / 1ps

module rswf_state #(
  parameter int unsigned SLOT_COUNT = rswf_pkg::SlotCountDef,
  parameter int unsigned KEY_BITS   = rswf_pkg::KeyBitsDef,
  parameter int unsigned IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  rswf_pkg::req_t       req_i,
  input  logic [KEY_BITS-1:0]  rd_key_i,
  input  logic                 elide_en_i,
  output rswf_pkg::rsp_t       rsp_o,
  output logic                 wr_en_o,
  output logic [IDX_W-1:0]     wr_idx_o,
  output logic [KEY_BITS-1:0]  wr_key_o
);

  localparam int unsigned ActCntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CW      = rswf_pkg::CountW;

  logic [SLOT_COUNT-1:0] valid_q, valid_d;
  logic [SLOT_COUNT-1:0] used_q, used_d;
  logic [ActCntW-1:0]    active_q, active_d;
  logic [CW-1:0]         gen_q, gen_d;
  logic [CW-1:0]         elided_q, elided_d;
  logic [CW-1:0]         applied_q, applied_d;
  logic [CW-1:0]         voided_q, voided_d;
  logic [CW-1:0]         inval_q, inval_d;
  logic [CW-1:0]         over_q, over_d;

  logic [63:0]          key_ext;
  logic [KEY_BITS-1:0]  key_m;
  logic [IDX_W-1:0]     idx;
  logic                 in_range;
  logic                 is_set, is_void, is_inval, is_bump;
  logic                 hit;
  logic [31:0]          active_ext;

  always_comb begin
    key_ext  = 64'(req_i.key);
    key_m    = key_ext[KEY_BITS-1:0];
    idx      = req_i.slot[IDX_W-1:0];
    in_range = (32'(req_i.slot) < 32'(SLOT_COUNT));
    is_set   = (req_i.req_type == rswf_pkg::REQ_SET);
    is_void  = (req_i.req_type == rswf_pkg::REQ_VOID);
    is_inval = (req_i.req_type == rswf_pkg::REQ_INVAL);
    is_bump  = (req_i.req_type == rswf_pkg::REQ_BUMP);
    hit      = is_set && in_range && elide_en_i && valid_q[idx] && (rd_key_i == key_m);

    valid_d   = valid_q;
    used_d    = used_q;
    active_d  = active_q;
    gen_d     = gen_q;
    elided_d  = elided_q;
    applied_d = applied_q;
    voided_d  = voided_q;
    inval_d   = inval_q;
    over_d    = over_q;
    wr_en_o   = 1'b0;

    if ((is_set || is_void) && !in_range) begin
      over_d = over_q + 1'b1;
    end else if (is_set) begin
      if (hit) begin
        elided_d = elided_q + 1'b1;
      end else begin
        applied_d   = applied_q + 1'b1;
        valid_d[idx] = 1'b1;
        wr_en_o     = fire_i;
      end
      if (!used_q[idx]) begin
        used_d[idx] = 1'b1;
        active_d    = active_q + 1'b1;
      end
    end else if (is_void) begin
      valid_d[idx] = 1'b0;
      voided_d     = voided_q + 1'b1;
    end else if (is_inval) begin
      valid_d = '0;
      inval_d = inval_q + 1'b1;
    end else if (is_bump) begin
      gen_d = gen_q + 1'b1;
    end

    active_ext = 32'(active_d);

    rsp_o.elide              = hit;
    rsp_o.slot_overflow      = (is_set || is_void) && !in_range;
    rsp_o.tex_gen            = gen_d;
    rsp_o.elided_total       = elided_d;
    rsp_o.applied_total      = applied_d;
    rsp_o.voided_total       = voided_d;
    rsp_o.invalidation_total = inval_d;
    rsp_o.overflow_total     = over_d;
    rsp_o.active_slots       = active_ext[rswf_pkg::ActiveW-1:0];
    // Every result follows at least one request, so touched always reads set.
    rsp_o.touched            = 1'b1;
  end

  assign wr_idx_o = idx;
  assign wr_key_o = key_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      used_q    <= '0;
      active_q  <= '0;
      gen_q     <= '0;
      elided_q  <= '0;
      applied_q <= '0;
      voided_q  <= '0;
      inval_q   <= '0;
      over_q    <= '0;
    end else if (fire_i) begin
      valid_q   <= valid_d;
      used_q    <= used_d;
      active_q  <= active_d;
      gen_q     <= gen_d;
      elided_q  <= elided_d;
      applied_q <= applied_d;
      voided_q  <= voided_d;
      inval_q   <= inval_d;
      over_q    <= over_d;
    end
  end

endmodule

// ===== rtl/redundant_state_write_filter.sv =====
`timescale 1ns / 1ps

// Redundant state-write filter.
// Requests enter on the req channel (req_valid_i / req_ready_o, payload req_i)
// and one result per request leaves on the rsp channel (rsp_valid_o /
// rsp_ready_i, payload rsp_o). A transaction is accepted at a rising edge with
// valid and ready both high.
// A request accepted into the request register moves to the result register
// on advance, which waits while a held result has not been taken.
// Throughput: one transaction per cycle while the receiver takes results.
// The request register reads the key memory on accept; one compare-and-update
// of a slot then runs between the request register and the result register.
// When the receiver stalls, hold the result register; the request register
// keeps taking one more transaction, then ready drops until the result moves.
// Reset clears all valid and used bits, all counters and the generation, and
// sets elide_enable; every result reports touched set. The key memory is not
// cleared: an entry is only compared while its valid bit is set, which a
// write sets. elide_enable is written by cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, which the block does not enforce.
module redundant_state_write_filter #(
  parameter int unsigned SLOT_COUNT = rswf_pkg::SlotCountDef,
  parameter int unsigned KEY_BITS   = rswf_pkg::KeyBitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  rswf_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output rswf_pkg::rsp_t rsp_o
);

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic                elide_en_q;
  logic                s1_valid_q;
  rswf_pkg::req_t      s1_q;
  logic                fwd_hit_q;
  logic [KEY_BITS-1:0] fwd_key_q;
  logic                out_valid_q;
  rswf_pkg::rsp_t      out_q;

  logic                accept;
  logic                advance;
  logic [KEY_BITS-1:0] ram_rd;
  logic [KEY_BITS-1:0] cur_key;
  logic                wr_en;
  logic [IdxW-1:0]     wr_idx;
  logic [KEY_BITS-1:0] wr_key;
  rswf_pkg::rsp_t      rsp_d;

  // Advance the request stage when the result register is free or draining.
  assign advance     = s1_valid_q && (!out_valid_q || rsp_ready_i);
  assign req_ready_o = !s1_valid_q || advance;
  assign accept      = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elide_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      elide_en_q <= cfg_wdata_i;
    end
  end

  rswf_key_ram #(
    .DEPTH  (SLOT_COUNT),
    .WIDTH  (KEY_BITS),
    .ADDR_W (IdxW)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_idx),
    .wr_data_i (wr_key),
    .rd_en_i   (accept),
    .rd_addr_i (req_i.slot[IdxW-1:0]),
    .rd_data_o (ram_rd)
  );

  // The memory returns pre-write data when the item ahead writes the same
  // slot at the accept edge; capture that key instead.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_hit_q  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        fwd_hit_q  <= wr_en && (wr_idx == req_i.slot[IdxW-1:0]);
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q      <= req_i;
      fwd_key_q <= wr_key;
    end
  end

  assign cur_key = fwd_hit_q ? fwd_key_q : ram_rd;

  rswf_state #(
    .SLOT_COUNT (SLOT_COUNT),
    .KEY_BITS   (KEY_BITS),
    .IDX_W      (IdxW)
  ) u_state (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .req_i      (s1_q),
    .rd_key_i   (cur_key),
    .elide_en_i (elide_en_q),
    .rsp_o      (rsp_d),
    .wr_en_o    (wr_en),
    .wr_idx_o   (wr_idx),
    .wr_key_o   (wr_key)
  );

  // Result register: load on advance, drop valid once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
